[rtl/sps_pkg.sv]
// ----------------------------------------------------------------------------
// Step pulse scheduler package
// Shared request and result types, command and fault codes, helpers.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QI_W = $clog2(QUEUE_DEPTH);
    localparam int QF_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] POS_BIAS = 32'h4000_0000;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_QUEUE     = 3'd1,
        CMD_SET_DIR   = 3'd2,
        CMD_RESET_CLK = 3'd3,
        CMD_GET_POS   = 3'd4,
        CMD_STOP      = 3'd5
    } cmd_t;

    localparam logic [2:0] FAULT_NONE       = 3'd0;
    localparam logic [2:0] FAULT_ZERO_COUNT = 3'd1;
    localparam logic [2:0] FAULT_TOO_PAST   = 3'd2;
    localparam logic [2:0] FAULT_RST_ACTIVE = 3'd3;
    localparam logic [2:0] FAULT_QUEUE_FULL = 3'd4;

    localparam logic [1:0] CFG_PULSE  = 2'd0;
    localparam logic [1:0] CFG_SINGLE = 2'd1;
    localparam logic [1:0] CFG_INVERT = 2'd2;
    localparam logic [1:0] CFG_PAST   = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic [31:0]        interval;
        logic [15:0]        step_count;
        logic signed [15:0] interval_delta;
        logic               direction;
        logic [31:0]        clock_value;
    } req_t;

    typedef struct packed {
        logic               step_level;
        logic               dir_level;
        logic               step_edge;
        logic               active;
        logic signed [31:0] position;
        logic [2:0]         fault;
        logic [4:0]         queue_used;
        logic               needs_reset;
    } res_t;

    // True when a lies before b on the wrapping time line.
    function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Position magnitude with the edges still pending taken off.
    function automatic logic [31:0] unbiased(input logic [31:0] bp, input logic [17:0] edges,
                                             input logic single);
        logic [31:0] p;
        p = bp - (single ? {14'd0, edges} : {15'd0, edges[17:1]});
        if (p[31])
        begin
            p = 32'd0 - p;
        end
        return p;
    endfunction

endpackage

[rtl/sps_cmd_queue.sv]
// ----------------------------------------------------------------------------
// Request queue
// Two-entry queue that takes requests in front of the step engine.
// ----------------------------------------------------------------------------
module sps_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sps_pkg::req_t wdata,
    output logic          full,
    output logic          valid,
    input  logic          take,
    output sps_pkg::req_t rdata
);
    import sps_pkg::*;

    req_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = cnt_reg == 2'd2;
    assign valid   = cnt_reg != 2'd0;
    assign rdata   = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = take && valid;

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

[rtl/sps_result_queue.sv]
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue that holds results until the consumer takes them.
// ----------------------------------------------------------------------------
module sps_result_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sps_pkg::res_t wdata,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output sps_pkg::res_t rdata
);
    import sps_pkg::*;

    res_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rdata   = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

[rtl/sps_engine.sv]
// ----------------------------------------------------------------------------
// Step engine
// Executes one request a cycle while go is high: timing, move queue, pins, position, faults.
// ----------------------------------------------------------------------------
module sps_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    input  logic          go,
    input  sps_pkg::req_t req,
    output sps_pkg::res_t res
);
    import sps_pkg::*;

    // Configuration registers.
    logic [15:0] pulse_reg;
    logic        single_reg;
    logic        invert_reg;
    logic [23:0] past_reg;

    // Scheduler state.
    logic [31:0] ct_reg, ct_next;
    logic [31:0] wake_reg, wake_next;
    logic [31:0] nst_reg, nst_next;
    logic [31:0] sint_reg, sint_next;
    logic [15:0] iadd_reg, iadd_next;
    logic [17:0] edges_reg, edges_next;
    logic [31:0] bp_reg, bp_next;
    logic        last_reg, last_next;
    logic        ndir_reg, ndir_next;
    logic        rn_reg, rn_next;
    logic        pin_reg, pin_next;
    logic        dpin_reg, dpin_next;
    logic [2:0]  fault_reg, fault_next;
    logic [QI_W-1:0] head_reg, head_next;
    logic [QI_W-1:0] tail_reg, tail_next;
    logic [QF_W-1:0] fill_reg, fill_next;

    // Move queue storage.
    logic [47:0] qt_mem [QUEUE_DEPTH];
    logic [16:0] qc_mem [QUEUE_DEPTH];

    logic        q_we;
    logic [47:0] q_wt;
    logic [16:0] q_wc;

    logic        do_load;
    logic        from_step;
    logic        bypass;
    logic        stop_req;
    logic [47:0] mv_t;
    logic [16:0] mv_c;
    logic [31:0] min_next;
    logic [31:0] min2;
    logic [31:0] late;
    logic [17:0] cnt;
    logic        dirflag;
    logic [31:0] pos;

    function automatic logic [QI_W-1:0] wrap_inc(input logic [QI_W-1:0] p);
        return (p == QI_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Request execution, in the order of the scheduling rules.
    always_comb
    begin
        ct_next = ct_reg;       wake_next = wake_reg;   nst_next = nst_reg;
        sint_next = sint_reg;   iadd_next = iadd_reg;   edges_next = edges_reg;
        bp_next = bp_reg;       last_next = last_reg;   ndir_next = ndir_reg;
        rn_next = rn_reg;       pin_next = pin_reg;     dpin_next = dpin_reg;
        fault_next = fault_reg; head_next = head_reg;   tail_next = tail_reg;
        fill_next = fill_reg;
        q_we = 1'b0;
        q_wt = {req.interval_delta, req.interval};
        q_wc = 17'd0;
        do_load = 1'b0;
        from_step = 1'b0;
        bypass = 1'b0;
        stop_req = 1'b0;
        min_next = '0;
        min2 = '0;
        late = '0;
        cnt = '0;
        dirflag = 1'b0;
        pos = '0;
        mv_t = '0;
        mv_c = '0;

        if (go)
        begin
            if (req.command == CMD_TICK)
            begin
                ct_next = ct_reg + 32'd1;
                if (fault_reg == FAULT_NONE && edges_reg != '0
                    && !is_before(ct_next, wake_reg))
                begin
                    // Step event.
                    pin_next = ~pin_reg;
                    min_next = ct_next + {16'd0, pulse_reg};
                    cnt = edges_reg - 18'd1;
                    if (cnt[0] && !single_reg)
                    begin
                        edges_next = cnt;
                        wake_next = min_next;
                    end
                    else if (cnt != '0)
                    begin
                        nst_next = nst_reg + sint_reg;
                        sint_next = sint_reg + sext16(iadd_reg);
                        edges_next = cnt;
                        wake_next = is_before(nst_next, min_next) ? min_next : nst_next;
                    end
                    else
                    begin
                        wake_next = min_next;
                        from_step = 1'b1;
                        if (fill_reg == '0)
                        begin
                            edges_next = '0;
                        end
                        else
                        begin
                            do_load = 1'b1;
                        end
                    end
                end
            end
            else if (fault_reg == FAULT_NONE)
            begin
                case (req.command)
                    CMD_QUEUE:
                    begin
                        if (fill_reg == QF_W'(QUEUE_DEPTH))
                        begin
                            fault_next = FAULT_QUEUE_FULL;
                            stop_req = 1'b1;
                        end
                        else if (req.step_count == 16'd0)
                        begin
                            fault_next = FAULT_ZERO_COUNT;
                            stop_req = 1'b1;
                        end
                        else if (!(edges_reg == '0 && rn_reg))
                        begin
                            dirflag = last_reg != ndir_reg;
                            last_next = last_reg ^ dirflag;
                            q_we = 1'b1;
                            q_wc = {dirflag, req.step_count};
                            tail_next = wrap_inc(tail_reg);
                            fill_next = fill_reg + 1'b1;
                            // An idle engine takes the new move at once.
                            if (edges_reg == '0)
                            begin
                                do_load = 1'b1;
                                bypass = 1'b1;
                            end
                        end
                    end
                    CMD_SET_DIR:
                    begin
                        ndir_next = req.direction;
                    end
                    CMD_RESET_CLK:
                    begin
                        if (edges_reg != '0)
                        begin
                            fault_next = FAULT_RST_ACTIVE;
                            stop_req = 1'b1;
                        end
                        else
                        begin
                            nst_next = req.clock_value;
                            wake_next = req.clock_value;
                            rn_next = 1'b0;
                        end
                    end
                    CMD_STOP:
                    begin
                        stop_req = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Load the next move from the queue.
            if (do_load)
            begin
                mv_t = bypass ? q_wt : qt_mem[head_reg];
                mv_c = bypass ? q_wc : qc_mem[head_reg];
                head_next = wrap_inc(head_reg);
                fill_next = fill_next - 1'b1;
                bp_next = (mv_c[16] ? (32'd0 - bp_next) : bp_next) + {16'd0, mv_c[15:0]};
                iadd_next = mv_t[47:32];
                sint_next = mv_t[31:0] + sext16(mv_t[47:32]);
                min2 = wake_next;
                nst_next = nst_next + mv_t[31:0];
                wake_next = nst_next;
                edges_next = single_reg ? {2'd0, mv_c[15:0]} : {1'b0, mv_c[15:0], 1'b0};
                late = min2 - nst_next;
                if (from_step && is_before(nst_next, min2) && late > {8'd0, past_reg})
                begin
                    fault_next = FAULT_TOO_PAST;
                    stop_req = 1'b1;
                end
                else
                begin
                    if (from_step && is_before(nst_next, min2))
                    begin
                        wake_next = min2;
                    end
                    if (mv_c[16])
                    begin
                        dpin_next = ~dpin_reg;
                        min_next = ct_next + {16'd0, pulse_reg};
                        if (from_step && is_before(wake_next, min_next))
                        begin
                            wake_next = min_next;
                        end
                    end
                end
            end

            // Stop, alone or as the tail of a fault; the first fault sticks.
            if (stop_req)
            begin
                if (fault_reg != FAULT_NONE)
                begin
                    fault_next = fault_reg;
                end
                pos = unbiased(bp_next, edges_next, single_reg);
                bp_next = 32'd0 - pos;
                nst_next = '0;
                wake_next = '0;
                edges_next = '0;
                last_next = 1'b0;
                ndir_next = 1'b0;
                rn_next = 1'b1;
                dpin_next = 1'b0;
                if (!single_reg)
                begin
                    pin_next = invert_reg;
                end
                head_next = '0;
                tail_next = '0;
                fill_next = '0;
            end
        end
    end

    // Result of the request being executed.
    always_comb
    begin
        res.step_level  = pin_next;
        res.dir_level   = dpin_next;
        res.step_edge   = pin_next ^ pin_reg;
        res.active      = edges_next != '0;
        res.position    = unbiased(bp_next, edges_next, single_reg) - POS_BIAS;
        res.fault       = fault_next;
        res.queue_used  = 5'(fill_next);
        res.needs_reset = rn_next;
    end

    // Move queue write port.
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qt_mem[tail_reg] <= q_wt;
            qc_mem[tail_reg] <= q_wc;
        end
    end

    // Configuration and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg <= 16'd32;   single_reg <= 1'b0;
            invert_reg <= 1'b0;    past_reg <= 24'd16000;
            ct_reg <= '0;    wake_reg <= '0;   nst_reg <= '0;   sint_reg <= '0;
            iadd_reg <= '0;  edges_reg <= '0;  bp_reg <= 32'd0 - POS_BIAS;
            last_reg <= 1'b0; ndir_reg <= 1'b0; rn_reg <= 1'b0;
            pin_reg <= 1'b0; dpin_reg <= 1'b0; fault_reg <= FAULT_NONE;
            head_reg <= '0;  tail_reg <= '0;   fill_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PULSE:  pulse_reg  <= cfg_data[15:0];
                    CFG_SINGLE: single_reg <= cfg_data[0];
                    CFG_INVERT: invert_reg <= cfg_data[0];
                    CFG_PAST:   past_reg   <= cfg_data;
                    default:    pulse_reg  <= pulse_reg;
                endcase
            end
            ct_reg <= ct_next;     wake_reg <= wake_next;   nst_reg <= nst_next;
            sint_reg <= sint_next; iadd_reg <= iadd_next;   edges_reg <= edges_next;
            bp_reg <= bp_next;     last_reg <= last_next;   ndir_reg <= ndir_next;
            rn_reg <= rn_next;     pin_reg <= pin_next;     dpin_reg <= dpin_next;
            fault_reg <= fault_next; head_reg <= head_next; tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

endmodule

[rtl/step_pulse_scheduler_core.sv]
// ----------------------------------------------------------------------------
// Step pulse scheduler core
// Plays queued stepper moves against a tick time base and reports pin state.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  request   push / full        item   (sps_pkg::req_t)
//  result    pop / empty        result (sps_pkg::res_t)
//  config    cfg_we             cfg_index, cfg_data
//
// One request is executed per clock while the result queue has room; a result
// passes the request queue and the result queue before it can be popped. The
// rate is one request a cycle, set by the single step engine. Reset clears all
// control state at once. A stalled result side fills the two-entry queues on
// each side of the engine, after which full is raised.
module step_pulse_scheduler_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  sps_pkg::req_t item,
    output logic          empty,
    input  logic          pop,
    output sps_pkg::res_t result,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [23:0]   cfg_data
);
    import sps_pkg::*;

    req_t req;
    res_t res;
    logic req_valid;
    logic res_full;
    logic go;

    assign go = req_valid && !res_full;

    // Front: request queue.
    sps_cmd_queue u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item),
        .full  (full),
        .valid (req_valid),
        .take  (go),
        .rdata (req)
    );

    // Back: step engine.
    sps_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .go        (go),
        .req       (req),
        .res       (res)
    );

    // Result queue.
    sps_result_queue u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (go),
        .wdata (res),
        .full  (res_full),
        .empty (empty),
        .pop   (pop),
        .rdata (result)
    );

endmodule
